FILE: sv/frame_rotate_flip_invert_unit_macros.svh
// Assertion macros for the frame rotate/flip/invert unit.
// Included by the top level; depends on nothing else.
`ifndef FRAME_ROTATE_FLIP_INVERT_UNIT_MACROS_SVH
`define FRAME_ROTATE_FLIP_INVERT_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRFI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRFI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/frfi_pkg.sv
// Shared constants, codes and helpers of the frame rotate/flip/invert unit.
// Used by the channel interfaces and the top level; depends on nothing.
package frfi_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int ROW_DW = $clog2(MAX_ROWS + 1);
    localparam int COL_DW = $clog2(MAX_COLS + 1);
    localparam int DIM_W  = (ROW_DW > COL_DW) ? ROW_DW : COL_DW;
    localparam int ROW_IW = $clog2(MAX_ROWS);
    localparam int COL_IW = $clog2(MAX_COLS);
    localparam int IDX_W  = (ROW_IW > COL_IW) ? ROW_IW : COL_IW;

    localparam int CH_W   = 8;
    localparam int WORD_W = 4 * CH_W;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_INVERT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ROT_RIGHT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROT_LEFT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLIP_ROWS = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLIP_COLS = 3'd4;

    localparam int RST_ROWS  = (256 > MAX_ROWS) ? MAX_ROWS : 256;
    localparam int RST_COLS  = (256 > MAX_COLS) ? MAX_COLS : 256;
    localparam int RST_TOTAL = RST_ROWS * RST_COLS;

    // A size of zero counts as one, a size above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input int unsigned maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > maxv) begin
            res = DIM_W'(maxv);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

endpackage

FILE: sv/frfi_in_if.sv
// Input channel of the frame rotate/flip/invert unit: load and drain requests.
// Depends on frfi_pkg.
interface frfi_in_if;
    import frfi_pkg::*;

    logic            valid;
    logic            ready;
    logic            kind;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_invalid;

    modport source (output valid, kind, in_red, in_green, in_blue, in_invalid,
                    input ready);
    modport sink   (input valid, kind, in_red, in_green, in_blue, in_invalid,
                    output ready);
endinterface

FILE: sv/frfi_out_if.sv
// Output channel of the frame rotate/flip/invert unit: transformed pixels.
// Depends on frfi_pkg.
interface frfi_out_if;
    import frfi_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_invalid;
    logic            frame_last;

    modport source (output valid, out_red, out_green, out_blue, out_invalid, frame_last,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_invalid, frame_last,
                    output ready);
endinterface

FILE: sv/frfi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module frfi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds while no read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/frame_rotate_flip_invert_unit.sv
// Frame rotate/flip/invert unit: loads a frame into a frame RAM, then drains it transformed.
// A drain gives its pixel via the RAM read stage and output register; loads give nothing.
// Throughput: one transaction per cycle unless output stalls (single RAM read/write port).
// Synchronous active-low reset clears counters, indices and configuration (mode 0,
// 256 by 256 frame); the frame RAM is not cleared and there is no clearing pass.
// Depends on frfi_pkg, frfi_in_if, frfi_out_if, frfi_ram and the assertion macros.
`include "frame_rotate_flip_invert_unit_macros.svh"

module frame_rotate_flip_invert_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    frfi_in_if.sink                        i_pix,
    frfi_out_if.source                     o_pix,
    input  logic                           i_cfg_we,
    input  logic [frfi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [frfi_pkg::CFG_W-1:0]     i_cfg_data
);
    import frfi_pkg::*;

    localparam int PROD_W = IDX_W + DIM_W;

    // Configuration, with sizes kept clamped and the pixel count precomputed.
    logic [MODE_W-1:0] r_mode;
    logic [DIM_W-1:0]  r_rows;
    logic [DIM_W-1:0]  r_cols;
    logic [CNT_W-1:0]  r_total;
    logic [DIM_W-1:0]  n_rows;
    logic [DIM_W-1:0]  n_cols;

    logic [CNT_W-1:0]  r_load_count;
    logic [CNT_W-1:0]  n_load_count;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic              r_ready;

    logic              r_s1_valid;
    logic              r_s1_inv;
    logic              r_s1_last;

    logic              r_o_valid;
    logic [CH_W-1:0]   r_o_red;
    logic [CH_W-1:0]   r_o_green;
    logic [CH_W-1:0]   r_o_blue;
    logic [CH_W-1:0]   r_o_invalid;
    logic              r_o_last;

    logic              in_fire;
    logic              ready_now;
    logic              load_fire;
    logic              drain_fire;
    logic              o_free;
    logic              hold;
    logic              rotate;
    logic [DIM_W-1:0]  orows;
    logic [DIM_W-1:0]  ocols;
    logic [IDX_W-1:0]  orows_m1;
    logic [IDX_W-1:0]  ocols_m1;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  c_idx;
    logic [IDX_W-1:0]  src_row;
    logic [IDX_W-1:0]  src_col;
    logic [PROD_W-1:0] rd_addr;
    logic              last;
    logic [WORD_W-1:0] ram_q;

    assign n_rows = clamp_dim(i_cfg_data, MAX_ROWS);
    assign n_cols = clamp_dim(i_cfg_data, MAX_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_INVERT;
            r_rows  <= DIM_W'(RST_ROWS);
            r_cols  <= DIM_W'(RST_COLS);
            r_total <= CNT_W'(RST_TOTAL);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE: begin
                    r_mode <= i_cfg_data[MODE_W-1:0];
                end
                CFG_ROWS: begin
                    r_rows  <= n_rows;
                    r_total <= CNT_W'((2*DIM_W)'(n_rows) * (2*DIM_W)'(r_cols));
                end
                CFG_COLS: begin
                    r_cols  <= n_cols;
                    r_total <= CNT_W'((2*DIM_W)'(r_rows) * (2*DIM_W)'(n_cols));
                end
                default: begin
                end
            endcase
        end
    end

    // The frame counts as complete once the load count reaches the pixel count.
    assign in_fire    = i_pix.valid && i_pix.ready;
    assign ready_now  = r_ready || (r_load_count >= r_total);
    assign load_fire  = in_fire && !i_pix.kind && !ready_now;
    assign drain_fire = in_fire && i_pix.kind && ready_now;
    assign n_load_count = r_load_count + CNT_W'(1);

    assign o_free = !r_o_valid || o_pix.ready;
    assign hold   = r_s1_valid && !o_free;
    // A held read stage keeps the RAM read data, so no new transaction is taken then,
    // and none is taken while reset is asserted.
    assign i_pix.ready = i_rst_n && !hold;

    // Target position, clamped to the current target size.
    assign rotate   = (r_mode == MODE_ROT_RIGHT) || (r_mode == MODE_ROT_LEFT);
    assign orows    = rotate ? r_cols : r_rows;
    assign ocols    = rotate ? r_rows : r_cols;
    assign orows_m1 = IDX_W'(orows - DIM_W'(1));
    assign ocols_m1 = IDX_W'(ocols - DIM_W'(1));
    assign r_idx    = (DIM_W'(r_row) < orows) ? r_row : orows_m1;
    assign c_idx    = (DIM_W'(r_col) < ocols) ? r_col : ocols_m1;
    assign last     = (r_idx == orows_m1) && (c_idx == ocols_m1);

    always_comb begin
        case (r_mode)
            MODE_ROT_RIGHT: begin
                src_row = IDX_W'(r_rows - DIM_W'(1) - DIM_W'(c_idx));
                src_col = r_idx;
            end
            MODE_ROT_LEFT: begin
                src_row = c_idx;
                src_col = IDX_W'(r_cols - DIM_W'(1) - DIM_W'(r_idx));
            end
            MODE_FLIP_ROWS: begin
                src_row = IDX_W'(r_rows - DIM_W'(1) - DIM_W'(r_idx));
                src_col = c_idx;
            end
            MODE_FLIP_COLS: begin
                src_row = r_idx;
                src_col = IDX_W'(r_cols - DIM_W'(1) - DIM_W'(c_idx));
            end
            default: begin
                src_row = r_idx;
                src_col = c_idx;
            end
        endcase
    end

    assign rd_addr = PROD_W'(src_row) * PROD_W'(r_cols) + PROD_W'(src_col);

    // Loads and drains never share a cycle, so a read never meets a write in flight.
    frfi_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (load_fire),
        .i_waddr (r_load_count[ADDR_W-1:0]),
        .i_wdata ({i_pix.in_red, i_pix.in_green, i_pix.in_blue, i_pix.in_invalid}),
        .i_re    (drain_fire),
        .i_raddr (rd_addr[ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_ready      <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (load_fire) begin
                r_load_count <= n_load_count;
                r_ready      <= (n_load_count >= r_total);
            end else if (drain_fire) begin
                if (last) begin
                    r_load_count <= '0;
                    r_row        <= '0;
                    r_col        <= '0;
                    r_ready      <= 1'b0;
                end else begin
                    r_ready <= 1'b1;
                    if (c_idx == ocols_m1) begin
                        r_col <= '0;
                        r_row <= r_idx + IDX_W'(1);
                    end else begin
                        r_col <= c_idx + IDX_W'(1);
                        r_row <= r_idx;
                    end
                end
            end else if (in_fire && ready_now) begin
                // A load into a complete frame is dropped but latches completion.
                r_ready <= 1'b1;
            end
            if (!hold) begin
                r_s1_valid <= drain_fire;
            end
            if (o_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_fire) begin
            r_s1_inv  <= (r_mode == MODE_INVERT);
            r_s1_last <= last;
        end
        if (o_free && r_s1_valid) begin
            // 255 minus a channel value is its bitwise complement.
            r_o_red     <= r_s1_inv ? ~ram_q[4*CH_W-1:3*CH_W] : ram_q[4*CH_W-1:3*CH_W];
            r_o_green   <= r_s1_inv ? ~ram_q[3*CH_W-1:2*CH_W] : ram_q[3*CH_W-1:2*CH_W];
            r_o_blue    <= r_s1_inv ? ~ram_q[2*CH_W-1:CH_W]   : ram_q[2*CH_W-1:CH_W];
            r_o_invalid <= ram_q[CH_W-1:0];
            r_o_last    <= r_s1_last;
        end
    end

    assign o_pix.valid       = r_o_valid;
    assign o_pix.out_red     = r_o_red;
    assign o_pix.out_green   = r_o_green;
    assign o_pix.out_blue    = r_o_blue;
    assign o_pix.out_invalid = r_o_invalid;
    assign o_pix.frame_last  = r_o_last;

    `FRFI_ASSERT_NEXT(a_drain_reaches_read_stage, i_clk, i_rst_n, drain_fire, r_s1_valid,
                      "served drain request did not reach the read stage")
    `FRFI_ASSERT_NEXT(a_last_restarts_loading, i_clk, i_rst_n, drain_fire && last,
                      (r_load_count == '0) && !r_ready && (r_row == '0) && (r_col == '0),
                      "last pixel did not return the block to loading")
    `FRFI_ASSERT_NEXT(a_held_read_keeps_data, i_clk, i_rst_n, hold,
                      r_s1_valid && $stable(ram_q), "held read stage lost its data")
    `FRFI_ASSERT_NOW(a_no_load_into_full_frame, i_clk, i_rst_n, load_fire,
                     r_load_count < r_total, "load written past the end of the frame")

endmodule
